// ===== src/rwcp_pkg.sv =====
package rwcp_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_SHORT_HDR  = 3'd1;
	localparam logic [2:0] ST_NOT_RIFF   = 3'd2;
	localparam logic [2:0] ST_SHORT_FMT  = 3'd3;
	localparam logic [2:0] ST_SHORT_DATA = 3'd4;
	localparam logic [2:0] ST_MISSING    = 3'd5;
	localparam logic [2:0] ST_NOT_PCM    = 3'd6;
	localparam logic [2:0] ST_LAYOUT     = 3'd7;

	localparam logic KIND_AUDIO  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [1:0] SF_MONO8    = 2'd0;
	localparam logic [1:0] SF_MONO16   = 2'd1;
	localparam logic [1:0] SF_STEREO8  = 2'd2;
	localparam logic [1:0] SF_STEREO16 = 2'd3;

	typedef struct packed {
		logic [7:0] file_byte;
		logic       end_of_file;
	} in_item_t;

	typedef struct packed {
		logic        item_kind;
		logic [7:0]  audio_byte;
		logic        new_data;
		logic [2:0]  status;
		logic [1:0]  sample_format;
		logic [31:0] sample_rate;
		logic        last;
	} out_item_t;

	// One parsed input byte: an optional audio byte followed by an optional status.
	typedef struct packed {
		logic        has_audio;
		logic [7:0]  audio_byte;
		logic        new_data;
		logic        has_status;
		logic [2:0]  status;
		logic [1:0]  sample_format;
		logic [31:0] sample_rate;
	} entry_t;

endpackage

// ===== src/rwcp_in_if.sv =====
interface rwcp_in_if;
	logic               valid;
	logic               ready;
	rwcp_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/rwcp_out_if.sv =====
interface rwcp_out_if;
	logic                valid;
	logic                ready;
	rwcp_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/riff_wav_chunk_parser_core.sv =====
// RIFF/WAVE header parser with streamed audio bytes.
// The in channel takes one file byte per item, with end_of_file set on the
// last byte of each file. The out channel returns audio items (item_kind 0),
// one per data-chunk byte, and exactly one status item (item_kind 1, last 1)
// per file carrying the status code, the sample format and the sample rate.
// A nonzero status invalidates audio already delivered for that file.
// Throughput is one input byte per cycle while the queue is not full. The
// front parser updates its counters and tag compares for each accepted byte;
// the output side drains one item per cycle while the receiver is ready, so
// the byte that yields both an audio item and the status is drained as two
// items, the extra one absorbed by the entry queue. An accepted byte's item
// passes through the queue and then the output register to the out channel.
// Reset clears the parser to expect a new RIFF header and empties the queue
// and the output register. When the receiver stalls, the output register
// holds its item, the queue fills, and in.ready drops once QUEUE_DEPTH
// entries are waiting.
module riff_wav_chunk_parser_core #(
	parameter int QUEUE_DEPTH = rwcp_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	rwcp_in_if.sink     in,
	rwcp_out_if.source  out
);

	logic             q_full;
	logic             q_push;
	rwcp_pkg::entry_t q_entry;
	logic             q_pop;
	logic             head_valid;
	rwcp_pkg::entry_t head_entry;

	rwcp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in      (in),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (q_entry)
	);

	rwcp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	rwcp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (q_pop),
		.out        (out)
	);

endmodule

// ===== src/rwcp_front.sv =====
module rwcp_front (
	input  logic             clk,
	input  logic             arst_n,
	rwcp_in_if.sink          in,
	input  logic             q_full,
	output logic             q_push,
	output rwcp_pkg::entry_t q_entry
);

	typedef enum logic [10:0] {
		PH_HEADER    = 11'b00000000001,
		PH_CID       = 11'b00000000010,
		PH_CSZ_FMT   = 11'b00000000100,
		PH_CSZ_DATA  = 11'b00000001000,
		PH_CSZ_OTHER = 11'b00000010000,
		PH_FMT_BODY  = 11'b00000100000,
		PH_FMT_SKIP  = 11'b00001000000,
		PH_DATA_BODY = 11'b00010000000,
		PH_SKIP      = 11'b00100000000,
		PH_PAD       = 11'b01000000000,
		PH_DONE      = 11'b10000000000
	} phase_t;

	localparam logic [31:0] TAG_RIFF = 32'h46464952;
	localparam logic [31:0] TAG_WAVE = 32'h45564157;
	localparam logic [31:0] TAG_FMT  = 32'h20746D66;
	localparam logic [31:0] TAG_DATA = 32'h61746164;
	localparam logic [31:0] FMT_BODY_LEN = 32'd16;

	phase_t      phase_q, phase_d;
	logic [31:0] pos_q, pos_d;
	logic [31:0] tag_q, tag_d;
	logic [31:0] len_q, len_d;
	logic [15:0] afmt_q, afmt_d;
	logic [15:0] chans_q, chans_d;
	logic [31:0] rate_q, rate_d;
	logic [15:0] bits_q, bits_d;
	logic        fmt_seen_q, fmt_seen_d;
	logic        data_seen_q, data_seen_d;

	logic        accept;
	logic [7:0]  b;
	logic [31:0] tag_sh;
	logic [31:0] pos_inc;
	logic [31:0] len_v;
	logic        chunk_end;
	logic        req_final;
	logic        emit_audio;
	logic        emit_status;
	logic        new_data;
	logic [2:0]  st_code;
	logic [1:0]  sf_v;
	logic [31:0] rate_out;

	assign in.ready = !q_full;
	assign accept   = in.valid && in.ready;
	assign b        = in.data.file_byte;
	assign tag_sh   = {b, tag_q[31:8]};
	assign pos_inc  = pos_q + 32'd1;

	always_comb begin
		phase_d     = phase_q;
		pos_d       = pos_q;
		tag_d       = tag_q;
		len_d       = len_q;
		afmt_d      = afmt_q;
		chans_d     = chans_q;
		rate_d      = rate_q;
		bits_d      = bits_q;
		fmt_seen_d  = fmt_seen_q;
		data_seen_d = data_seen_q;
		len_v       = len_q;
		chunk_end   = 1'b0;
		req_final   = 1'b0;
		emit_audio  = 1'b0;
		emit_status = 1'b0;
		new_data    = 1'b0;
		st_code     = rwcp_pkg::ST_OK;
		sf_v        = rwcp_pkg::SF_MONO8;
		rate_out    = 32'd0;

		case (phase_q)
			PH_HEADER: begin
				tag_d = tag_sh;
				pos_d = pos_inc;
				if (pos_inc == 32'd4) begin
					len_d = (tag_sh == TAG_RIFF) ? 32'd1 : 32'd0;
				end
				if (pos_inc == 32'd12) begin
					pos_d = 32'd0;
					if (len_q == 32'd1 && tag_sh == TAG_WAVE) begin
						phase_d = PH_CID;
					end else begin
						emit_status = 1'b1;
						st_code     = rwcp_pkg::ST_NOT_RIFF;
						phase_d     = PH_DONE;
					end
				end
			end
			PH_CID: begin
				tag_d = tag_sh;
				pos_d = pos_inc;
				if (pos_inc == 32'd4) begin
					pos_d = 32'd0;
					if (tag_sh == TAG_FMT) begin
						phase_d = PH_CSZ_FMT;
					end else if (tag_sh == TAG_DATA) begin
						phase_d = PH_CSZ_DATA;
					end else begin
						phase_d = PH_CSZ_OTHER;
					end
				end
			end
			PH_CSZ_FMT, PH_CSZ_DATA, PH_CSZ_OTHER: begin
				tag_d = tag_sh;
				pos_d = pos_inc;
				if (pos_inc == 32'd4) begin
					pos_d = 32'd0;
					len_d = tag_sh;
					len_v = tag_sh;
					if (phase_q == PH_CSZ_FMT) begin
						phase_d = PH_FMT_BODY;
					end else if (phase_q == PH_CSZ_DATA) begin
						if (tag_sh == 32'd0) begin
							data_seen_d = 1'b1;
							chunk_end   = 1'b1;
						end else begin
							phase_d = PH_DATA_BODY;
						end
					end else begin
						if (tag_sh == 32'd0) begin
							chunk_end = 1'b1;
						end else begin
							phase_d = PH_SKIP;
						end
					end
				end
			end
			PH_FMT_BODY: begin
				// The position stays below 16 in this phase.
				case (pos_q[3:0])
					4'd0:    afmt_d  = {8'h00, b};
					4'd1:    afmt_d  = {b, afmt_q[7:0]};
					4'd2:    chans_d = {8'h00, b};
					4'd3:    chans_d = {b, chans_q[7:0]};
					4'd4:    rate_d  = {24'h000000, b};
					4'd5:    rate_d  = {rate_q[31:16], b, rate_q[7:0]};
					4'd6:    rate_d  = {rate_q[31:24], b, rate_q[15:0]};
					4'd7:    rate_d  = {b, rate_q[23:0]};
					4'd14:   bits_d  = {8'h00, b};
					4'd15:   bits_d  = {b, bits_q[7:0]};
					default: ;
				endcase
				pos_d = pos_inc;
				if (pos_inc == FMT_BODY_LEN) begin
					fmt_seen_d = 1'b1;
					pos_d      = 32'd0;
					if (data_seen_q) begin
						req_final = 1'b1;
					end else if (len_q > FMT_BODY_LEN) begin
						phase_d = PH_FMT_SKIP;
					end else begin
						chunk_end = 1'b1;
					end
				end
			end
			PH_FMT_SKIP: begin
				pos_d = pos_inc;
				if (pos_inc == len_q - FMT_BODY_LEN) begin
					chunk_end = 1'b1;
				end
			end
			PH_DATA_BODY: begin
				emit_audio = 1'b1;
				new_data   = (pos_q == 32'd0);
				pos_d      = pos_inc;
				if (pos_inc == len_q) begin
					data_seen_d = 1'b1;
					chunk_end   = 1'b1;
				end
			end
			PH_SKIP: begin
				pos_d = pos_inc;
				if (pos_inc == len_q) begin
					chunk_end = 1'b1;
				end
			end
			PH_PAD: begin
				phase_d = PH_CID;
				pos_d   = 32'd0;
			end
			default: ;
		endcase

		// A finished chunk body either completes the parse or leads to pad or next id.
		if (chunk_end) begin
			pos_d = 32'd0;
			if (fmt_seen_d && data_seen_d) begin
				req_final = 1'b1;
			end else begin
				phase_d = len_v[0] ? PH_PAD : PH_CID;
			end
		end

		if (req_final) begin
			emit_status = 1'b1;
			phase_d     = PH_DONE;
			if (afmt_d != 16'd1) begin
				st_code = rwcp_pkg::ST_NOT_PCM;
			end else if (chans_d == 16'd1 && bits_d == 16'd8) begin
				sf_v     = rwcp_pkg::SF_MONO8;
				rate_out = rate_d;
			end else if (chans_d == 16'd1 && bits_d == 16'd16) begin
				sf_v     = rwcp_pkg::SF_MONO16;
				rate_out = rate_d;
			end else if (chans_d == 16'd2 && bits_d == 16'd8) begin
				sf_v     = rwcp_pkg::SF_STEREO8;
				rate_out = rate_d;
			end else if (chans_d == 16'd2 && bits_d == 16'd16) begin
				sf_v     = rwcp_pkg::SF_STEREO16;
				rate_out = rate_d;
			end else begin
				st_code = rwcp_pkg::ST_LAYOUT;
			end
		end

		if (in.data.end_of_file) begin
			if (phase_d != PH_DONE) begin
				emit_status = 1'b1;
				if (phase_d == PH_HEADER) begin
					st_code = rwcp_pkg::ST_SHORT_HDR;
				end else if (phase_d == PH_FMT_BODY) begin
					st_code = rwcp_pkg::ST_SHORT_FMT;
				end else if (phase_d == PH_DATA_BODY) begin
					st_code = rwcp_pkg::ST_SHORT_DATA;
				end else begin
					st_code = rwcp_pkg::ST_MISSING;
				end
			end
			phase_d     = PH_HEADER;
			pos_d       = 32'd0;
			tag_d       = 32'd0;
			len_d       = 32'd0;
			afmt_d      = 16'd0;
			chans_d     = 16'd0;
			rate_d      = 32'd0;
			bits_d      = 16'd0;
			fmt_seen_d  = 1'b0;
			data_seen_d = 1'b0;
		end
	end

	assign q_push                = accept && (emit_audio || emit_status);
	assign q_entry.has_audio     = emit_audio;
	assign q_entry.audio_byte    = b;
	assign q_entry.new_data      = new_data;
	assign q_entry.has_status    = emit_status;
	assign q_entry.status        = st_code;
	assign q_entry.sample_format = sf_v;
	assign q_entry.sample_rate   = rate_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			pos_q       <= 32'd0;
			tag_q       <= 32'd0;
			len_q       <= 32'd0;
			afmt_q      <= 16'd0;
			chans_q     <= 16'd0;
			rate_q      <= 32'd0;
			bits_q      <= 16'd0;
			fmt_seen_q  <= 1'b0;
			data_seen_q <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_d;
			pos_q       <= pos_d;
			tag_q       <= tag_d;
			len_q       <= len_d;
			afmt_q      <= afmt_d;
			chans_q     <= chans_d;
			rate_q      <= rate_d;
			bits_q      <= bits_d;
			fmt_seen_q  <= fmt_seen_d;
			data_seen_q <= data_seen_d;
		end
	end

endmodule

// ===== src/rwcp_queue.sv =====
module rwcp_queue #(
	parameter int DEPTH = rwcp_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rwcp_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output rwcp_pkg::entry_t head_entry
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	rwcp_pkg::entry_t   mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full       = (count_q == FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop && !full) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not grow on push");

endmodule

// ===== src/rwcp_back.sv =====
module rwcp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  rwcp_pkg::entry_t head_entry,
	output logic             pop,
	rwcp_out_if.source       out
);

	logic                out_valid_q;
	rwcp_pkg::out_item_t out_q;
	logic                audio_done_q;

	logic                load;
	logic                take_audio;
	rwcp_pkg::out_item_t item;

	assign load       = !out_valid_q || out.ready;
	assign take_audio = head_valid && head_entry.has_audio && !audio_done_q;
	// An entry with an audio byte and a status stays at the head until its status loads.
	assign pop        = load && head_valid && !(take_audio && head_entry.has_status);

	always_comb begin
		if (take_audio) begin
			item.item_kind     = rwcp_pkg::KIND_AUDIO;
			item.audio_byte    = head_entry.audio_byte;
			item.new_data      = head_entry.new_data;
			item.status        = rwcp_pkg::ST_OK;
			item.sample_format = rwcp_pkg::SF_MONO8;
			item.sample_rate   = 32'd0;
			item.last          = 1'b0;
		end else begin
			item.item_kind     = rwcp_pkg::KIND_STATUS;
			item.audio_byte    = 8'd0;
			item.new_data      = 1'b0;
			item.status        = head_entry.status;
			item.sample_format = head_entry.sample_format;
			item.sample_rate   = head_entry.sample_rate;
			item.last          = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			audio_done_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				audio_done_q <= take_audio && head_entry.has_status;
			end
		end
	end

	assign out.valid = out_valid_q;
	assign out.data  = out_q;

	a_done_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		audio_done_q |-> head_valid)
		else $error("audio marked sent with no entry at the head");

	a_done_pair: assert property (@(posedge clk) disable iff (!arst_n)
		audio_done_q |-> (head_entry.has_audio && head_entry.has_status))
		else $error("audio marked sent for an entry without a status");

	a_pair_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head_entry.has_audio && head_entry.has_status) |-> audio_done_q)
		else $error("entry popped before its audio byte was sent");

endmodule
